// ===== design/md5_pkg.sv =====
`timescale 1ns / 1ps
// Package for the MD5 hash engine: initial chaining words, padding constants,
// round constant ROM, rotation table, message word schedule and round functions.
// Depends on nothing; used by md5_hash_engine.
package md5_pkg;

	// Initial chaining value words A, B, C, D.
	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	// Padding byte that follows the last message byte.
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Block geometry.
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned WORD_BITS   = 32;
	localparam logic [3:0]  FILL_LEN_LO = 4'd14;
	localparam logic [3:0]  FILL_LEN_HI = 4'd15;
	localparam logic [6:0]  LAST_STEP   = 7'd64;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PAD  = 5'b00010,
		ST_COMP = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_HOLD = 5'b10000
	} md5_state_t;

	// Sine-derived round constant for one step.
	function automatic logic [31:0] round_const(input logic [5:0] step);
		logic [31:0] k;
		case (step)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Left rotate amount, indexed by round and step within a group of four.
	function automatic logic [4:0] rot_amount(input logic [5:0] step);
		logic [4:0] r;
		case ({step[5:4], step[1:0]})
			4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
			4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
			4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
			4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;  4'd15: r = 5'd21;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Message word used by a step; all arithmetic is modulo 16.
	function automatic logic [3:0] msg_sel(input logic [5:0] step);
		logic [3:0] s;
		logic [3:0] w;
		s = step[3:0];
		case (step[5:4])
			2'd0:    w = s;
			2'd1:    w = 4'((s << 2) + s + 4'd1);
			2'd2:    w = 4'((s << 1) + s + 4'd5);
			default: w = 4'((s << 3) - s);
		endcase
		return w;
	endfunction

	// Nonlinear round function of B, C and D.
	function automatic logic [31:0] mix_fn(input logic [1:0] phase, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] m;
		case (phase)
			2'd0:    m = (b & c) | (~b & d);
			2'd1:    m = (b & d) | (c & ~d);
			2'd2:    m = b ^ c ^ d;
			default: m = c ^ (b | ~d);
		endcase
		return m;
	endfunction

	// 32-bit left rotate by a variable amount.
	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] t;
		t = {x, x} << n;
		return t[63:32];
	endfunction

endpackage

// ===== design/md5_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module md5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/md5_hash_engine.sv =====
`timescale 1ns / 1ps
// MD5 hash engine top level: word buffer in a RAM, padding sequencer,
// one-step-per-cycle compression and digest output register.
// Depends on md5_pkg and md5_ram.
//
// Usage:
// The message enters on the data channel (data_valid / data_stall), one 32-bit
// word per transfer, first byte in bits 7:0. The word with last_word set ends
// the message and carries 0 to 4 valid low bytes in tail_bytes (5 to 7 count as 4).
// Words are written into a 16-entry block RAM, one per cycle while data_stall is
// low. The sixteenth word starts a compression that reads the RAM once per step
// and then folds the result into the chaining words. data_stall is high whenever
// the engine is not idle: while padding words are written, a compression runs,
// its result is folded, or a finished digest waits for the output register.
// After the last word the engine writes the padding and the 64-bit bit length
// (one or two more blocks), then presents the four digest words A, B, C, D on
// the digest channel with word_index 0 to 3 and last_of_run on the fourth.
// The digest sits in its own output register, so a new message is accepted
// while the digest drains; a stalled digest only holds back the end of the
// next message. Reset (arst_n low) loads the initial chaining value, empties
// the block and drops any pending digest.
module md5_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  tail_bytes,
	input  logic        last_word,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_of_run
);

	md5_pkg::md5_state_t state_q;

	logic [31:0] cv_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [3:0]  fill_q;
	logic [63:0] bits_q;
	logic [6:0]  step_q;
	logic        pad_q, mark_q, lo_done_q, hi_done_q;
	logic [31:0] dig_q [4];
	logic        out_busy_q;
	logic [1:0]  out_idx_q;

	logic        accept;
	logic        push_en;
	logic [31:0] push_data;
	logic [3:0]  rd_addr;
	logic [31:0] rd_data;
	logic [5:0]  rnd;
	logic [31:0] round_sum;
	logic [31:0] new_b;
	logic        full_tail;
	logic        out_done;

	// Handshakes.
	assign data_stall = (state_q != md5_pkg::ST_IDLE);
	assign accept     = data_valid && !data_stall;
	assign full_tail  = tail_bytes[2];
	assign out_done   = out_busy_q && !digest_stall && (out_idx_q == 2'd3);

	// Word written into the block this cycle, from the input or the pad sequencer.
	always_comb begin
		push_en   = 1'b0;
		push_data = data_word;
		case (state_q)
			md5_pkg::ST_IDLE: begin
				push_en = accept;
				if (last_word && !full_tail) begin
					case (tail_bytes[1:0])
						2'd0:    push_data = {24'd0, md5_pkg::PAD_BYTE};
						2'd1:    push_data = {16'd0, md5_pkg::PAD_BYTE, data_word[7:0]};
						2'd2:    push_data = {8'd0, md5_pkg::PAD_BYTE, data_word[15:0]};
						default: push_data = {md5_pkg::PAD_BYTE, data_word[23:0]};
					endcase
				end
			end
			md5_pkg::ST_PAD: begin
				push_en = 1'b1;
				if (mark_q) begin
					push_data = {24'd0, md5_pkg::PAD_BYTE};
				end else if (fill_q == md5_pkg::FILL_LEN_LO) begin
					push_data = bits_q[31:0];
				end else if (fill_q == md5_pkg::FILL_LEN_HI && lo_done_q) begin
					push_data = bits_q[63:32];
				end else begin
					push_data = 32'd0;
				end
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	// Block buffer.
	assign rd_addr = md5_pkg::msg_sel(step_q[5:0]);

	md5_ram #(
		.WIDTH(md5_pkg::WORD_BITS),
		.DEPTH(md5_pkg::BLOCK_WORDS)
	) u_block_ram (
		.clk     (clk),
		.wr_en   (push_en),
		.wr_addr (fill_q),
		.wr_data (push_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// One compression step on the word read in the previous cycle.
	assign rnd       = 6'(step_q[5:0] - 6'd1);
	assign round_sum = a_q + md5_pkg::mix_fn(rnd[5:4], b_q, c_q, d_q) + rd_data
		+ md5_pkg::round_const(rnd);
	assign new_b     = b_q + md5_pkg::rotl32(round_sum, md5_pkg::rot_amount(rnd));

	// Controller, block fill, length count and chaining words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= md5_pkg::ST_IDLE;
			cv_q[0]   <= md5_pkg::IV_A;
			cv_q[1]   <= md5_pkg::IV_B;
			cv_q[2]   <= md5_pkg::IV_C;
			cv_q[3]   <= md5_pkg::IV_D;
			fill_q    <= 4'd0;
			bits_q    <= 64'd0;
			step_q    <= 7'd0;
			pad_q     <= 1'b0;
			mark_q    <= 1'b0;
			lo_done_q <= 1'b0;
			hi_done_q <= 1'b0;
		end else begin
			// Fill pointer; the sixteenth word starts a compression.
			if (push_en) begin
				if (fill_q == md5_pkg::FILL_LEN_HI) begin
					fill_q <= 4'd0;
				end else begin
					fill_q <= fill_q + 4'd1;
				end
			end
			case (state_q)
				md5_pkg::ST_IDLE: begin
					if (accept) begin
						if (!last_word) begin
							bits_q <= bits_q + 64'd32;
						end else begin
							bits_q    <= bits_q + (full_tail ? 64'd32 : {59'd0, tail_bytes[1:0], 3'd0});
							pad_q     <= 1'b1;
							mark_q    <= full_tail;
							lo_done_q <= 1'b0;
							hi_done_q <= 1'b0;
						end
						if (fill_q == md5_pkg::FILL_LEN_HI) begin
							state_q <= md5_pkg::ST_COMP;
							step_q  <= 7'd0;
						end else if (last_word) begin
							state_q <= md5_pkg::ST_PAD;
						end
					end
				end
				md5_pkg::ST_PAD: begin
					if (mark_q) begin
						mark_q <= 1'b0;
					end else if (fill_q == md5_pkg::FILL_LEN_LO) begin
						lo_done_q <= 1'b1;
					end else if (fill_q == md5_pkg::FILL_LEN_HI && lo_done_q) begin
						hi_done_q <= 1'b1;
					end
					if (fill_q == md5_pkg::FILL_LEN_HI) begin
						state_q <= md5_pkg::ST_COMP;
						step_q  <= 7'd0;
					end
				end
				md5_pkg::ST_COMP: begin
					if (step_q == md5_pkg::LAST_STEP) begin
						state_q <= md5_pkg::ST_FIN;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				md5_pkg::ST_FIN: begin
					cv_q[0] <= cv_q[0] + a_q;
					cv_q[1] <= cv_q[1] + b_q;
					cv_q[2] <= cv_q[2] + c_q;
					cv_q[3] <= cv_q[3] + d_q;
					if (pad_q && hi_done_q) begin
						state_q <= md5_pkg::ST_HOLD;
					end else if (pad_q) begin
						state_q <= md5_pkg::ST_PAD;
					end else begin
						state_q <= md5_pkg::ST_IDLE;
					end
				end
				md5_pkg::ST_HOLD: begin
					// Hand the digest over once the output register is free.
					if (!out_busy_q || out_done) begin
						cv_q[0]   <= md5_pkg::IV_A;
						cv_q[1]   <= md5_pkg::IV_B;
						cv_q[2]   <= md5_pkg::IV_C;
						cv_q[3]   <= md5_pkg::IV_D;
						bits_q    <= 64'd0;
						pad_q     <= 1'b0;
						lo_done_q <= 1'b0;
						hi_done_q <= 1'b0;
						state_q   <= md5_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= md5_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Working variables: loaded at the first step, then one step per cycle.
	always_ff @(posedge clk) begin
		if (state_q == md5_pkg::ST_COMP) begin
			if (step_q == 7'd0) begin
				a_q <= cv_q[0];
				b_q <= cv_q[1];
				c_q <= cv_q[2];
				d_q <= cv_q[3];
			end else begin
				a_q <= d_q;
				b_q <= new_b;
				c_q <= b_q;
				d_q <= c_q;
			end
		end
	end

	// Digest output register and word counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
			out_idx_q  <= 2'd0;
		end else begin
			if (state_q == md5_pkg::ST_HOLD && (!out_busy_q || out_done)) begin
				out_busy_q <= 1'b1;
				out_idx_q  <= 2'd0;
			end else if (out_busy_q && !digest_stall) begin
				out_idx_q <= out_idx_q + 2'd1;
				if (out_idx_q == 2'd3) begin
					out_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == md5_pkg::ST_HOLD && (!out_busy_q || out_done)) begin
			dig_q[0] <= cv_q[0];
			dig_q[1] <= cv_q[1];
			dig_q[2] <= cv_q[2];
			dig_q[3] <= cv_q[3];
		end
	end

	assign digest_valid = out_busy_q;
	assign digest_word  = dig_q[out_idx_q];
	assign word_index   = out_idx_q;
	assign last_of_run  = (out_idx_q == 2'd3);

	// The block buffer is never written while a compression reads it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == md5_pkg::ST_COMP) |-> !push_en)
		else $error("block RAM written during compression");

	// A compression always starts and runs on an emptied fill pointer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == md5_pkg::ST_COMP) |-> (fill_q == 4'd0))
		else $error("fill pointer not cleared during compression");

	// Once the high length word is written, the block has been closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		hi_done_q |-> (fill_q == 4'd0))
		else $error("length written but block still open");

	// The step counter never runs past the last step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == md5_pkg::ST_COMP) |-> (step_q <= md5_pkg::LAST_STEP))
		else $error("compression step counter overrun");

	// Digest words leave in order without gaps.
	assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && !last_of_run) |=>
		(digest_valid && word_index == 2'($past(word_index) + 2'd1)))
		else $error("digest word sequence broken");

endmodule
